// ===== sv/ttdos_pkg.sv =====
package ttdos_pkg;

  localparam int DELAY_DEPTH = 32768;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int LANE_W      = 16;
  localparam int REG_W       = 3 * LANE_W;
  // Q.16 value of 1.0 needs one extra bit
  localparam int UNIT_W      = LANE_W + 1;
  localparam int DIV_CNT_W   = $clog2(UNIT_W + 1);

  localparam logic [REG_W-1:0] MOD_RESET = 48'h1000_1000_1000;
  localparam logic [UNIT_W-1:0] ONE_Q16  = 17'h10000;

  typedef enum logic [2:0] {
    REG_TAP_DELAYS   = 3'd0,
    REG_PHASE_SHIFTS = 3'd1,
    REG_FREQ_GAINS   = 3'd2,
    REG_AMP_GAINS    = 3'd3,
    REG_MOD_GAINS    = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_CLIP,
    ST_DIV,
    ST_FREQ,
    ST_WRAP,
    ST_SQUARE,
    ST_PARAB,
    ST_AMP,
    ST_LANE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [UNIT_W-1:0] num;   // dividend is num << 16
    logic [UNIT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [UNIT_W-1:0] quo;
  } div_rsp_t;

  // Fold a Q.16 value above 1.0 back into (0, 1]; values up to 1.0 pass.
  function automatic logic [UNIT_W-1:0] wrap_unit(input logic [31:0] v);
    logic [UNIT_W-1:0] r;
    if (v <= 32'(ONE_Q16)) begin
      r = v[UNIT_W-1:0];
    end else if (v[LANE_W-1:0] == '0) begin
      r = ONE_Q16;
    end else begin
      r = {1'b0, v[LANE_W-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== sv/three_tap_delayed_overtone_shaper.sv =====
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata[15:0] drive_in
// m_*      out  m_tvalid/m_tready   m_tdata overtone_first/second/third
// cfg_*    in   cfg_we              cfg_addr register index, cfg_data value
//
// A transaction runs from accept to its final load, and no new drive sample
// is taken before that load: the three taps go one after another through one
// shared datapath, each waiting in ST_DIV on the divider's bit-per-cycle loop.
// Reset (rst, synchronous) clears control and config but sets mod gains to 16'h1000;
// the delay memory needs no clearing pass, a fill flag makes never-written
// entries read as zero. A waiting result sits in the output register; a new
// transaction is taken meanwhile and only its final load waits for m_tready.
module three_tap_delayed_overtone_shaper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] drive_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] first, [31:16] second, [47:32] third
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_data
);

  localparam int AW = ttdos_pkg::ADDR_W;
  localparam int LW = ttdos_pkg::LANE_W;
  localparam int UW = ttdos_pkg::UNIT_W;

  // configuration
  logic [ttdos_pkg::REG_W-1:0] tap_delays, phase_shifts, freq_gains, amp_gains, mod_gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_delays   <= '0;
      phase_shifts <= '0;
      freq_gains   <= '0;
      amp_gains    <= '0;
      mod_gains    <= ttdos_pkg::MOD_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ttdos_pkg::REG_TAP_DELAYS:   tap_delays   <= cfg_data;
        ttdos_pkg::REG_PHASE_SHIFTS: phase_shifts <= cfg_data;
        ttdos_pkg::REG_FREQ_GAINS:   freq_gains   <= cfg_data;
        ttdos_pkg::REG_AMP_GAINS:    amp_gains    <= cfg_data;
        ttdos_pkg::REG_MOD_GAINS:    mod_gains    <= cfg_data;
        default: ;
      endcase
    end
  end

  ttdos_pkg::state_t state, state_next;
  logic [1:0] tap;

  // lane of the current tap
  logic [LW-1:0] l_delay, l_shift, l_freq, l_amp, l_mod;
  always_comb begin
    case (tap)
      2'd0: begin
        l_delay = tap_delays[15:0];   l_shift = phase_shifts[15:0];
        l_freq  = freq_gains[15:0];   l_amp   = amp_gains[15:0];
        l_mod   = mod_gains[15:0];
      end
      2'd1: begin
        l_delay = tap_delays[31:16];  l_shift = phase_shifts[31:16];
        l_freq  = freq_gains[31:16];  l_amp   = amp_gains[31:16];
        l_mod   = mod_gains[31:16];
      end
      default: begin
        l_delay = tap_delays[47:32];  l_shift = phase_shifts[47:32];
        l_freq  = freq_gains[47:32];  l_amp   = amp_gains[47:32];
        l_mod   = mod_gains[47:32];
      end
    endcase
  end

  // delay memory, write position and fill flag
  logic [LW-1:0] mem [ttdos_pkg::DELAY_DEPTH];
  logic [AW-1:0] wp, item_wp;
  logic          full;
  logic          accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (accept) begin
      wp <= wp + 1'b1;
      if (wp == AW'(ttdos_pkg::DELAY_DEPTH - 1)) begin
        full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_wp <= wp;
    end
  end

  // tap address: delays past the end clamp to the oldest entry
  logic [AW-1:0] rd_addr;
  logic          rd_written;
  always_comb begin
    if (32'(l_delay) > 32'(ttdos_pkg::DELAY_DEPTH - 1)) begin
      rd_addr = item_wp - AW'(ttdos_pkg::DELAY_DEPTH - 1);
    end else begin
      rd_addr = item_wp - AW'(l_delay);
    end
    rd_written = full || (rd_addr <= item_wp);
  end

  logic [LW-1:0] rd_q;
  logic          rd_ok;
  always_ff @(posedge clk) begin
    if (state == ttdos_pkg::ST_READ) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= rd_written;
    end
  end

  // divider
  ttdos_pkg::div_req_t div_req;
  ttdos_pkg::div_rsp_t div_rsp;

  ttdos_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath registers
  logic [31:0]   prod1;   // drive * mod
  logic [31:0]   k1;      // shift * freq
  logic [UW-1:0] d;       // modulated drive, wrapped
  logic [48:0]   prod2;   // r * k1
  logic [LW-1:0] vabs;    // |w - 0.5|
  logic [31:0]   sq;
  logic [47:0]   prod3;   // parabola * (1 - d)
  logic [31:0]   prod4;   // q * amp
  logic [LW-1:0] res [3];

  logic [UW-1:0] d_c, c_c, w_c, dinv_c;
  logic [52:0]   prod2x12;
  logic [31:0]   p_c;
  logic [35:0]   prod4x12;

  always_comb begin
    d_c      = ttdos_pkg::wrap_unit({12'd0, prod1[31:12]});
    c_c      = (d_c > UW'(l_shift)) ? d_c - UW'(l_shift) : '0;
    prod2x12 = ({4'd0, prod2} << 3) + ({4'd0, prod2} << 2);
    w_c      = ttdos_pkg::wrap_unit({3'd0, prod2x12[52:24]});
    p_c      = 32'h8000_0000 - {sq[30:0], 1'b0};
    dinv_c   = ttdos_pkg::ONE_Q16 - d;
    prod4x12 = ({4'd0, prod4} << 3) + ({4'd0, prod4} << 2);
  end

  always_ff @(posedge clk) begin
    case (state)
      ttdos_pkg::ST_MUL: begin
        prod1 <= 32'(rd_ok ? rd_q : '0) * 32'(l_mod);
        k1    <= 32'(l_shift) * 32'(l_freq);
      end
      ttdos_pkg::ST_CLIP: d <= d_c;
      ttdos_pkg::ST_FREQ: prod2 <= 49'(div_rsp.quo) * 49'(k1);
      ttdos_pkg::ST_WRAP: begin
        vabs <= (w_c >= UW'(32768)) ? LW'(w_c - UW'(32768)) : LW'(UW'(32768) - w_c);
      end
      ttdos_pkg::ST_SQUARE: sq <= 32'(vabs) * 32'(vabs);
      ttdos_pkg::ST_PARAB:  prod3 <= 48'(p_c) * 48'(dinv_c);
      ttdos_pkg::ST_AMP:    prod4 <= 32'(prod3[47:32]) * 32'(l_amp);
      // product stays below 2^36, so the Q4.12 result never saturates
      ttdos_pkg::ST_LANE:   res[tap] <= prod4x12[35:20];
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttdos_pkg::ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      if (state == ttdos_pkg::ST_IDLE) begin
        tap <= '0;
      end else if (state == ttdos_pkg::ST_LANE) begin
        tap <= (tap == 2'd2) ? 2'd0 : tap + 1'b1;
      end
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ttdos_pkg::ST_IDLE:   if (s_tvalid) state_next = ttdos_pkg::ST_READ;
      ttdos_pkg::ST_READ:   state_next = ttdos_pkg::ST_MUL;
      ttdos_pkg::ST_MUL:    state_next = ttdos_pkg::ST_CLIP;
      ttdos_pkg::ST_CLIP:   state_next = ttdos_pkg::ST_DIV;
      ttdos_pkg::ST_DIV:    if (div_rsp.done) state_next = ttdos_pkg::ST_FREQ;
      ttdos_pkg::ST_FREQ:   state_next = ttdos_pkg::ST_WRAP;
      ttdos_pkg::ST_WRAP:   state_next = ttdos_pkg::ST_SQUARE;
      ttdos_pkg::ST_SQUARE: state_next = ttdos_pkg::ST_PARAB;
      ttdos_pkg::ST_PARAB:  state_next = ttdos_pkg::ST_AMP;
      ttdos_pkg::ST_AMP:    state_next = ttdos_pkg::ST_LANE;
      ttdos_pkg::ST_LANE:   state_next = (tap == 2'd2) ? ttdos_pkg::ST_LOAD : ttdos_pkg::ST_READ;
      ttdos_pkg::ST_LOAD:   if (out_free) state_next = ttdos_pkg::ST_IDLE;
      default:              state_next = ttdos_pkg::ST_IDLE;
    endcase
  end

  logic load;
  always_comb begin
    s_tready      = (state == ttdos_pkg::ST_IDLE);
    load          = (state == ttdos_pkg::ST_LOAD) && out_free;
    div_req.start = (state == ttdos_pkg::ST_CLIP);
    div_req.num   = c_c;
    div_req.den   = ttdos_pkg::ONE_Q16 - UW'(l_shift);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {res[2], res[1], res[0]};
    end
  end

  a_wp_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> wp == $past(wp) + 1'b1)
    else $error("write position did not advance on accept");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ttdos_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    tap != 2'd3)
    else $error("tap index out of range");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

// ===== sv/ttdos_div.sv =====
// Restoring divider: quo = (num << 16) / den, one quotient bit per cycle.
// Caller guarantees num <= den so the quotient fits UNIT_W bits.
module ttdos_div (
  input  logic                clk,
  input  logic                rst,
  input  ttdos_pkg::div_req_t req,
  output ttdos_pkg::div_rsp_t rsp
);

  logic [ttdos_pkg::UNIT_W-1:0]    rem;
  logic [ttdos_pkg::UNIT_W-1:0]    sh;
  logic [ttdos_pkg::UNIT_W-1:0]    den;
  logic [ttdos_pkg::UNIT_W-1:0]    quo;
  logic [ttdos_pkg::DIV_CNT_W-1:0] cnt;
  logic                            busy;
  logic [ttdos_pkg::UNIT_W:0]      trial;
  logic                            ge;

  assign trial = {rem, sh[ttdos_pkg::UNIT_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= ttdos_pkg::DIV_CNT_W'(ttdos_pkg::UNIT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ttdos_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.num[ttdos_pkg::UNIT_W-1:1]};
      sh  <= {req.num[0], {(ttdos_pkg::UNIT_W-1){1'b0}}};
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? ttdos_pkg::UNIT_W'(trial - {1'b0, den}) : trial[ttdos_pkg::UNIT_W-1:0];
      sh  <= sh << 1;
      quo <= {quo[ttdos_pkg::UNIT_W-2:0], ge};
    end
  end

  assign rsp.done = busy && (cnt == ttdos_pkg::DIV_CNT_W'(1));
  assign rsp.quo  = quo;

endmodule

// ===== dv/three_tap_delayed_overtone_shaper_check.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port; predicts each result of the
// shaper lane by lane and compares it with what comes out.
module three_tap_delayed_overtone_shaper_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [47:0] delays, shifts, freqs, amps, mods;
  logic [15:0] drive_hist [ttdos_pkg::DELAY_DEPTH];
  logic [ttdos_pkg::ADDR_W-1:0] wr_pos;
  logic [47:0] overtone_q[$];

  assign pending = overtone_q.size();

  function automatic logic [16:0] fold_unit(input longint unsigned v);
    if (v <= 65536) return 17'(v);
    if (v[15:0] == 0) return 17'h10000;
    return {1'b0, v[15:0]};
  endfunction

  function automatic logic [15:0] shape_lane(input logic [15:0] drv, mod, s, fr, amp);
    longint unsigned d, c, r, k, w, p, q, o;
    longint v;
    d = fold_unit((64'(drv) * mod) >> 12);
    c = (d > s ? d : 64'(s)) - s;
    r = (c << 16) / (65536 - 64'(s));
    k = 64'(s) * fr * 12;
    w = fold_unit((r * k) >> 24);
    v = longint'(w) - 32768;
    p = 64'h8000_0000 - 2 * longint'(v * v);
    q = (p * (65536 - d)) >> 32;
    o = (q * amp * 12) >> 20;
    return o > 65535 ? 16'hFFFF : o[15:0];
  endfunction

  always_ff @(posedge clk) begin
    logic [47:0] res;
    logic [15:0] dl;
    logic [ttdos_pkg::ADDR_W-1:0] pos;
    logic [15:0] tapv;
    if (rst) begin
      delays <= '0; shifts <= '0; freqs <= '0; amps <= '0; mods <= ttdos_pkg::MOD_RESET;
      wr_pos <= '0;
      fail_count <= 0;
      overtone_q.delete();
      for (int i = 0; i < ttdos_pkg::DELAY_DEPTH; i++) drive_hist[i] = '0;
    end else begin
      if (cfg_we) begin
        case (ttdos_pkg::reg_idx_t'(cfg_addr))
          ttdos_pkg::REG_TAP_DELAYS:   delays <= cfg_data;
          ttdos_pkg::REG_PHASE_SHIFTS: shifts <= cfg_data;
          ttdos_pkg::REG_FREQ_GAINS:   freqs  <= cfg_data;
          ttdos_pkg::REG_AMP_GAINS:    amps   <= cfg_data;
          ttdos_pkg::REG_MOD_GAINS:    mods   <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        drive_hist[wr_pos] = s_tdata;
        for (int i = 0; i < 3; i++) begin
          dl = delays[16*i +: 16];
          if (dl > ttdos_pkg::DELAY_DEPTH - 1) dl = 16'(ttdos_pkg::DELAY_DEPTH - 1);
          pos = wr_pos - dl[ttdos_pkg::ADDR_W-1:0];
          tapv = drive_hist[pos];
          res[16*i +: 16] = shape_lane(tapv, mods[16*i +: 16], shifts[16*i +: 16],
                                       freqs[16*i +: 16], amps[16*i +: 16]);
        end
        overtone_q.push_back(res);
        wr_pos <= wr_pos + 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (overtone_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          res = overtone_q.pop_front();
          if (res !== m_tdata) begin
            if (fail_count < 10)
              $display("result mismatch: expected %h got %h", res, m_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/three_tap_delayed_overtone_shaper_test.sv =====
`timescale 1ns / 1ps

module three_tap_delayed_overtone_shaper_test;

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [47:0] cfg_data;
  int          fail_count, pending;

  // idle odds out of 100 per side; hold_off forces a long receiver stall
  int src_idle, snk_idle;
  bit hold_off;
  int quiet_cycles;

  three_tap_delayed_overtone_shaper dut (.*);
  three_tap_delayed_overtone_shaper_check chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off while the sender keeps offering
  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 0;
        repeat (600) @(negedge clk);
        hold_off = 0;
      end
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // watchdog: declares a mismatch and ends the run when the ports stay quiet past the limit
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("three_tap_delayed_overtone_shaper: mismatch");
      $finish;
    end
  end

  // s_tvalid stays up between back-to-back items; drain drops it
  task automatic send_drive(input logic [15:0] drv);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= drv;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // register writes only when nothing is in flight
  task automatic drain;
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // cfg_we is dropped by the caller after the last write of a burst
  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we   <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  function automatic logic [47:0] rand_lanes(input int max_lane);
    return {16'($urandom_range(max_lane)), 16'($urandom_range(max_lane)),
            16'($urandom_range(max_lane))};
  endfunction

  task automatic random_settings(input int mode);
    // mode 0 random, 1 all zeros, 2 all ones
    logic [47:0] v [5];
    for (int i = 0; i < 5; i++)
      v[i] = mode == 1 ? '0 : mode == 2 ? '1 : 48'({$urandom, $urandom});
    // short delays keep the history interesting; huge ones hit the clamp
    if (mode == 0 && $urandom_range(3) != 0) v[0] = rand_lanes(40);
    write_reg(ttdos_pkg::REG_TAP_DELAYS, v[0]);
    write_reg(ttdos_pkg::REG_PHASE_SHIFTS, v[1]);
    write_reg(ttdos_pkg::REG_FREQ_GAINS, v[2]);
    write_reg(ttdos_pkg::REG_AMP_GAINS, v[3]);
    write_reg(ttdos_pkg::REG_MOD_GAINS, v[4]);
    // unknown index must be ignored
    write_reg(3'd7, 48'({$urandom, $urandom}));
    cfg_we <= 0;
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0;
    cfg_we = 0; cfg_addr = ttdos_pkg::REG_TAP_DELAYS; cfg_data = 0;
    src_idle = 0; snk_idle = 0; hold_off = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset settings, then extremes and delay clamp
    send_drive(16'h0000); send_drive(16'hFFFF); send_drive(16'h8000);
    send_drive(16'h0001);
    drain();
    write_reg(ttdos_pkg::REG_TAP_DELAYS, {16'hFFFF, 16'd32768, 16'd1});
    write_reg(ttdos_pkg::REG_PHASE_SHIFTS, {16'hFFFF, 16'h8000, 16'h0000});
    write_reg(ttdos_pkg::REG_FREQ_GAINS, {16'hFFFF, 16'h0100, 16'h0A00});
    write_reg(ttdos_pkg::REG_AMP_GAINS, 48'hFFFF_FFFF_FFFF);
    write_reg(ttdos_pkg::REG_MOD_GAINS, {16'hFFFF, 16'h0000, 16'h3000});
    cfg_we <= 0;
    for (int i = 0; i < 10; i++) send_drive(i[0] ? 16'hFFFF : 16'($urandom));
    drain();
    random_settings(1);
    for (int i = 0; i < 4; i++) send_drive(16'($urandom));
    drain();
    random_settings(2);
    for (int i = 0; i < 4; i++) send_drive(16'($urandom));

    // random phases with the idling mixes
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      random_settings(0);
      case (ph % 4)
        0: begin src_idle = 0;  snk_idle = 0;  end
        1: begin src_idle = 87; snk_idle = 0;  end
        2: begin src_idle = 0;  snk_idle = 87; end
        default: begin src_idle = 14; snk_idle = 14; end
      endcase
      if (ph == 4) hold_off = 1;
      for (int i = 0; i < 95; i++) begin
        send_drive($urandom_range(3) == 0 ? ($urandom_range(1) ? 16'hFFFF : 16'h0)
                                          : 16'($urandom));
        if (ph == 6 && i == 40) drain();
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("three_tap_delayed_overtone_shaper: match");
    else
      $display("three_tap_delayed_overtone_shaper: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ttdos_pkg.sv
sv/ttdos_div.sv
sv/three_tap_delayed_overtone_shaper.sv
dv/three_tap_delayed_overtone_shaper_check.sv
dv/three_tap_delayed_overtone_shaper_test.sv
